>>> rtl/core/htw_pkg.sv
// Package with the sizes, codes and types shared by the timing wheel files.
`default_nettype none
package htw_pkg;
    localparam int LEVEL_ONE_SLOTS   = 4096;
    localparam int LEVEL_TWO_SLOTS   = 1024;
    localparam int LEVEL_THREE_SLOTS = 256;
    localparam int TIMER_COUNT       = 32;
    localparam int SLOT_TOTAL  = LEVEL_ONE_SLOTS + LEVEL_TWO_SLOTS + LEVEL_THREE_SLOTS;
    localparam int L1_W        = $clog2(LEVEL_ONE_SLOTS);
    localparam int L2_W        = $clog2(LEVEL_TWO_SLOTS);
    localparam int SLOT_W      = $clog2(SLOT_TOTAL);
    localparam int ID_W        = 5;
    localparam int CNT_W       = 6;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FAR     = 2'd1;
    localparam logic [1:0] STAT_NOT_PND = 2'd2;
    localparam logic [1:0] STAT_ALREADY = 2'd3;

    typedef struct packed {
        logic            used;
        logic [ID_W-1:0] head;
        logic [ID_W-1:0] tail;
    } t_slot_ent;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_FIN, S_RM_FIN, S_UL_RD, S_UL_SLOT, S_UL_DO,
        S_AP_RD, S_AP_DO, S_CS_HEAD, S_CS_CHK, S_CS_PLACE, S_FR_HEAD, S_FR_CHK,
        S_FR_EMIT
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/hierarchical_timer_wheel.sv
// Top level of the three-level timing wheel with its sequencer and timer store.
`default_nettype none
// After reset the block clears its 5376 slot entries, one per cycle, and holds
// busy high while it clears them. A stored add steps through S_AP_RD, S_AP_DO
// and S_ADD_FIN, and a remove through S_UL_RD, S_UL_SLOT, S_UL_DO and S_RM_FIN,
// since the accesses to the slot memory and the timer memories are serial and
// each has a registered read. A rejected add or remove, an add that fires at
// once and the unused operation are answered from the idle state. A tick walks
// the due level-one slot and fires each timer in it. At a level-one window
// boundary it first walks the due level-two slot and moves its timers. At a
// level-two boundary it first walks the due level-three slot, when one exists.
// Results come one per cycle at most with o_strobe high for one cycle; the
// receiver cannot stall them, and every transaction ends with o_last.
module hierarchical_timer_wheel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_operation,
    input  wire logic [4:0]  i_timer_id,
    input  wire logic [31:0] i_wake_time,
    output logic             busy,
    output logic             o_strobe,
    output logic [4:0]       o_expired_id,
    output logic             o_fired,
    output logic             o_last,
    output logic [1:0]       o_status,
    output logic [5:0]       o_pending_count
);
    localparam int SW = htw_pkg::SLOT_W;
    localparam int IW = htw_pkg::ID_W;
    localparam int CW = htw_pkg::CNT_W;
    localparam int L1 = htw_pkg::L1_W;
    localparam int L2 = htw_pkg::L2_W;
    localparam int TC = htw_pkg::TIMER_COUNT;
    localparam int LEVEL_BASE2 = htw_pkg::LEVEL_ONE_SLOTS;
    localparam int LEVEL_BASE3 = htw_pkg::LEVEL_ONE_SLOTS + htw_pkg::LEVEL_TWO_SLOTS;

    htw_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [IW-1:0] r_id, n_id;
    logic [31:0]   r_wake, n_wake, r_w, n_w, r_time, n_time;
    logic [IW-1:0] r_nx, n_nx, r_pv, n_pv;
    logic [SW-1:0] r_dst, n_dst, r_clr, n_clr;
    logic [TC-1:0] r_pend, n_pend;
    logic [CW-1:0] r_count, n_count, r_guard, n_guard, r_hcnt, n_hcnt;
    logic          r_lvl3, n_lvl3, r_have, n_have;
    logic [IW-1:0] r_hid, n_hid;
    logic          r_strobe, n_strobe, r_fired, n_fired, r_last, n_last;
    logic [IW-1:0] r_eid, n_eid;
    logic [1:0]    r_status, n_status;
    logic [CW-1:0] r_pcnt, n_pcnt;

    logic [31:0]   r_tw [TC];
    logic [IW-1:0] r_tn [TC];
    logic [IW-1:0] r_tp [TC];
    logic [SW-1:0] r_ts [TC];
    logic [31:0]   r_tw_q;
    logic [IW-1:0] r_tn_q, r_tp_q;
    logic [SW-1:0] r_ts_q;

    logic          tw_we, tn_we, tp_we, ts_we;
    logic [IW-1:0] tn_addr, tp_addr, tn_data, tp_data;

    logic                 sm_we;
    logic [SW-1:0]        sm_waddr, sm_raddr;
    htw_pkg::t_slot_ent   sm_wdata, sm_q;

    htw_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_q)
    );

    always_ff @(posedge i_clk) begin
        if (tw_we) begin
            r_tw[r_id] <= r_wake;
        end
        if (tn_we) begin
            r_tn[tn_addr] <= tn_data;
        end
        if (tp_we) begin
            r_tp[tp_addr] <= tp_data;
        end
        if (ts_we) begin
            r_ts[r_id] <= r_dst;
        end
        r_tw_q <= r_tw[r_id];
        r_tn_q <= r_tn[r_id];
        r_tp_q <= r_tp[r_id];
        r_ts_q <= r_ts[r_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htw_pkg::S_CLEAR;
            r_ret    <= htw_pkg::S_IDLE;
            r_clr    <= '0;
            r_time   <= '0;
            r_pend   <= '0;
            r_count  <= '0;
            r_guard  <= '0;
            r_lvl3   <= 1'b0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_clr    <= n_clr;
            r_time   <= n_time;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_guard  <= n_guard;
            r_lvl3   <= n_lvl3;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
        r_id     <= n_id;
        r_wake   <= n_wake;
        r_w      <= n_w;
        r_nx     <= n_nx;
        r_pv     <= n_pv;
        r_dst    <= n_dst;
        r_hcnt   <= n_hcnt;
        r_hid    <= n_hid;
        r_fired  <= n_fired;
        r_last   <= n_last;
        r_eid    <= n_eid;
        r_status <= n_status;
        r_pcnt   <= n_pcnt;
    end

    logic [SW-1:0] src_addr;
    logic          done_loop;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_id     = r_id;
        n_wake   = r_wake;
        n_w      = r_w;
        n_time   = r_time;
        n_nx     = r_nx;
        n_pv     = r_pv;
        n_dst    = r_dst;
        n_clr    = r_clr;
        n_pend   = r_pend;
        n_count  = r_count;
        n_guard  = r_guard;
        n_lvl3   = r_lvl3;
        n_have   = r_have;
        n_hid    = r_hid;
        n_hcnt   = r_hcnt;
        n_strobe = 1'b0;
        n_eid    = '0;
        n_fired  = 1'b0;
        n_last   = 1'b1;
        n_status = htw_pkg::STAT_OK;
        n_pcnt   = r_count;
        tw_we    = 1'b0;
        tn_we    = 1'b0;
        tp_we    = 1'b0;
        ts_we    = 1'b0;
        tn_addr  = r_id;
        tp_addr  = r_id;
        tn_data  = r_id;
        tp_data  = r_id;
        sm_we    = 1'b0;
        sm_waddr = r_dst;
        sm_wdata = '0;
        sm_raddr = r_dst;
        busy     = (r_state != htw_pkg::S_IDLE);
        src_addr = r_lvl3
            ? SW'(LEVEL_BASE3 + 32'(r_time[31:L1+L2]))
            : SW'(LEVEL_BASE2 + 32'(r_time[L1+L2-1:L1]));
        done_loop = !sm_q.used || (r_guard == CW'(TC));

        case (r_state)
            htw_pkg::S_CLEAR: begin
                sm_we    = 1'b1;
                sm_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == SW'(htw_pkg::SLOT_TOTAL - 1)) begin
                    n_state = htw_pkg::S_IDLE;
                end
            end
            htw_pkg::S_IDLE: begin
                if (start) begin
                    n_id   = i_timer_id;
                    n_wake = i_wake_time;
                    case (i_operation)
                        htw_pkg::OP_ADD: begin
                            if ({1'b0, i_timer_id} >= (IW+1)'(TC)) begin
                                n_strobe = 1'b1;
                                n_status = htw_pkg::STAT_NOT_PND;
                            end else if (r_pend[i_timer_id]) begin
                                n_strobe = 1'b1;
                                n_status = htw_pkg::STAT_ALREADY;
                            end else if (i_wake_time < r_time) begin
                                n_strobe = 1'b1;
                                n_fired  = 1'b1;
                                n_eid    = i_timer_id;
                            end else if (i_wake_time[31:L1] == r_time[31:L1]) begin
                                n_dst   = SW'(i_wake_time[L1-1:0]);
                                n_ret   = htw_pkg::S_ADD_FIN;
                                n_state = htw_pkg::S_AP_RD;
                            end else if (i_wake_time[31:L1+L2] == r_time[31:L1+L2]) begin
                                n_dst   = SW'(LEVEL_BASE2 + 32'(i_wake_time[L1+L2-1:L1]));
                                n_ret   = htw_pkg::S_ADD_FIN;
                                n_state = htw_pkg::S_AP_RD;
                            end else if (32'(i_wake_time[31:L1+L2])
                                         < 32'(htw_pkg::LEVEL_THREE_SLOTS)) begin
                                n_dst   = SW'(LEVEL_BASE3 + 32'(i_wake_time[31:L1+L2]));
                                n_ret   = htw_pkg::S_ADD_FIN;
                                n_state = htw_pkg::S_AP_RD;
                            end else begin
                                n_strobe = 1'b1;
                                n_status = htw_pkg::STAT_FAR;
                            end
                        end
                        htw_pkg::OP_REMOVE: begin
                            if ({1'b0, i_timer_id} >= (IW+1)'(TC)
                                || !r_pend[i_timer_id]) begin
                                n_strobe = 1'b1;
                                n_status = htw_pkg::STAT_NOT_PND;
                            end else begin
                                n_ret   = htw_pkg::S_RM_FIN;
                                n_state = htw_pkg::S_UL_RD;
                            end
                        end
                        htw_pkg::OP_TICK: begin
                            n_guard = '0;
                            n_have  = 1'b0;
                            if (r_time[L1-1:0] == '0) begin
                                n_lvl3  = (r_time[L1+L2-1:L1] == '0) &&
                                          (32'(r_time[31:L1+L2])
                                           < 32'(htw_pkg::LEVEL_THREE_SLOTS));
                                n_state = htw_pkg::S_CS_HEAD;
                            end else begin
                                n_state = htw_pkg::S_FR_HEAD;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            htw_pkg::S_ADD_FIN: begin
                tw_we            = 1'b1;
                n_pend[r_id]     = 1'b1;
                n_count          = r_count + 1'b1;
                n_strobe         = 1'b1;
                n_pcnt           = r_count + 1'b1;
                n_state          = htw_pkg::S_IDLE;
            end
            htw_pkg::S_RM_FIN: begin
                n_pend[r_id] = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_pcnt   = n_count;
                n_strobe = 1'b1;
                n_state  = htw_pkg::S_IDLE;
            end
            htw_pkg::S_UL_RD: begin
                n_state = htw_pkg::S_UL_SLOT;
            end
            htw_pkg::S_UL_SLOT: begin
                n_w      = r_tw_q;
                n_nx     = r_tn_q;
                n_pv     = r_tp_q;
                n_dst    = r_ts_q;
                sm_raddr = r_ts_q;
                n_state  = htw_pkg::S_UL_DO;
            end
            htw_pkg::S_UL_DO: begin
                n_state = r_ret;
                if (sm_q.used) begin
                    if (sm_q.head == r_id && sm_q.tail == r_id) begin
                        sm_we = 1'b1;
                    end else if (sm_q.head == r_id) begin
                        sm_we    = 1'b1;
                        sm_wdata = '{used: 1'b1, head: r_nx, tail: sm_q.tail};
                    end else if (sm_q.tail == r_id) begin
                        sm_we    = 1'b1;
                        sm_wdata = '{used: 1'b1, head: sm_q.head, tail: r_pv};
                    end else begin
                        tn_we   = 1'b1;
                        tn_addr = r_pv;
                        tn_data = r_nx;
                        tp_we   = 1'b1;
                        tp_addr = r_nx;
                        tp_data = r_pv;
                    end
                end
            end
            htw_pkg::S_AP_RD: begin
                n_state = htw_pkg::S_AP_DO;
            end
            htw_pkg::S_AP_DO: begin
                sm_we   = 1'b1;
                ts_we   = 1'b1;
                n_state = r_ret;
                if (!sm_q.used) begin
                    sm_wdata = '{used: 1'b1, head: r_id, tail: r_id};
                end else begin
                    sm_wdata = '{used: 1'b1, head: sm_q.head, tail: r_id};
                    tn_we    = 1'b1;
                    tn_addr  = sm_q.tail;
                    tp_we    = 1'b1;
                    tp_data  = sm_q.tail;
                end
            end
            htw_pkg::S_CS_HEAD: begin
                sm_raddr = src_addr;
                n_state  = htw_pkg::S_CS_CHK;
            end
            htw_pkg::S_CS_CHK: begin
                if (done_loop) begin
                    n_guard = '0;
                    if (r_lvl3) begin
                        n_lvl3  = 1'b0;
                        n_state = htw_pkg::S_CS_HEAD;
                    end else begin
                        n_state = htw_pkg::S_FR_HEAD;
                    end
                end else begin
                    n_id    = sm_q.head;
                    n_ret   = htw_pkg::S_CS_PLACE;
                    n_state = htw_pkg::S_UL_RD;
                end
            end
            htw_pkg::S_CS_PLACE: begin
                n_guard = r_guard + 1'b1;
                n_ret   = htw_pkg::S_CS_HEAD;
                n_state = htw_pkg::S_AP_RD;
                if (r_lvl3 && r_w[31:L1] != r_time[31:L1]) begin
                    n_dst = SW'(LEVEL_BASE2 + 32'(r_w[L1+L2-1:L1]));
                end else begin
                    n_dst = SW'(r_w[L1-1:0]);
                end
            end
            htw_pkg::S_FR_HEAD: begin
                sm_raddr = SW'(r_time[L1-1:0]);
                n_state  = htw_pkg::S_FR_CHK;
            end
            htw_pkg::S_FR_CHK: begin
                if (done_loop) begin
                    n_strobe = 1'b1;
                    if (r_have) begin
                        n_eid   = r_hid;
                        n_fired = 1'b1;
                        n_pcnt  = r_hcnt;
                    end
                    n_time  = r_time + 1'b1;
                    n_state = htw_pkg::S_IDLE;
                end else begin
                    n_id    = sm_q.head;
                    n_ret   = htw_pkg::S_FR_EMIT;
                    n_state = htw_pkg::S_UL_RD;
                end
            end
            htw_pkg::S_FR_EMIT: begin
                n_pend[r_id] = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                if (r_have) begin
                    n_strobe = 1'b1;
                    n_eid    = r_hid;
                    n_fired  = 1'b1;
                    n_last   = 1'b0;
                    n_pcnt   = r_hcnt;
                end
                n_have  = 1'b1;
                n_hid   = r_id;
                n_hcnt  = n_count;
                n_guard = r_guard + 1'b1;
                n_state = htw_pkg::S_FR_HEAD;
            end
            default: begin
                n_state = htw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe        = r_strobe;
    assign o_expired_id    = r_eid;
    assign o_fired         = r_fired;
    assign o_last          = r_last;
    assign o_status        = r_status;
    assign o_pending_count = r_pcnt;
endmodule
`default_nettype wire

>>> rtl/core/htw_slot_mem.sv
// Slot list memory holding the used flag, head and tail of every wheel slot.
`default_nettype none
module htw_slot_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [htw_pkg::SLOT_W-1:0] i_waddr,
    input  wire htw_pkg::t_slot_ent         i_wdata,
    input  wire logic [htw_pkg::SLOT_W-1:0] i_raddr,
    output htw_pkg::t_slot_ent              o_rdata
);
    htw_pkg::t_slot_ent r_mem [htw_pkg::SLOT_TOTAL];
    htw_pkg::t_slot_ent r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the three-level timing wheel with a built-in wheel predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import htw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         RUN_LIMIT = 1000000;

    typedef struct packed {
        logic [4:0] id;
        logic       fired;
        logic       last;
        logic [1:0] status;
        logic [5:0] count;
    } wheel_result_t;

    class wheel_scoreboard;
        logic [31:0]       now;
        logic [31:0]       wake_at [TIMER_COUNT];
        logic [4:0]        link_next [TIMER_COUNT];
        logic [4:0]        link_prev [TIMER_COUNT];
        int                home_slot [TIMER_COUNT];
        bit                armed [TIMER_COUNT];
        logic [4:0]        slot_head [SLOT_TOTAL];
        logic [4:0]        slot_tail [SLOT_TOTAL];
        bit                slot_used [SLOT_TOTAL];
        int                armed_total;
        wheel_result_t     due_results[$];
        int                errors;

        function new();
            now = 0;
            armed_total = 0;
            errors = 0;
            foreach (armed[i]) armed[i] = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function void link_timer(int id, int s);
            if (!slot_used[s]) begin
                slot_head[s] = id;
                slot_tail[s] = id;
                slot_used[s] = 1;
            end else begin
                link_next[slot_tail[s]] = id;
                link_prev[id] = slot_tail[s];
                slot_tail[s] = id;
            end
            home_slot[id] = s;
        endfunction

        function void unlink_timer(int id);
            int s;
            s = home_slot[id];
            if (!slot_used[s]) return;
            if (slot_head[s] == id && slot_tail[s] == id) begin
                slot_used[s] = 0;
            end else if (slot_head[s] == id) begin
                slot_head[s] = link_next[id];
            end else if (slot_tail[s] == id) begin
                slot_tail[s] = link_prev[id];
            end else begin
                link_next[link_prev[id]] = link_next[id];
                link_prev[link_next[id]] = link_prev[id];
            end
        endfunction

        function void push(logic [4:0] id, logic fired, logic [1:0] status);
            wheel_result_t r;
            r = '{id: id, fired: fired, last: 1'b0, status: status, count: armed_total[5:0]};
            due_results.push_back(r);
        endfunction

        function void note_input(logic [1:0] op, logic [4:0] id, logic [31:0] wake);
            int src;
            int f;
            int n;
            logic [31:0] w;
            n = due_results.size();
            case (op)
                OP_ADD: begin
                    if (armed[id]) begin
                        push(0, 0, STAT_ALREADY);
                    end else if (wake < now) begin
                        push(id, 1, STAT_OK);
                    end else if (wake[31:12] == now[31:12]) begin
                        wake_at[id] = wake;
                        link_timer(id, wake[11:0]);
                        armed[id] = 1;
                        armed_total++;
                        push(0, 0, STAT_OK);
                    end else if (wake[31:22] == now[31:22]) begin
                        wake_at[id] = wake;
                        link_timer(id, LEVEL_ONE_SLOTS + wake[21:12]);
                        armed[id] = 1;
                        armed_total++;
                        push(0, 0, STAT_OK);
                    end else if (wake[31:22] < LEVEL_THREE_SLOTS) begin
                        wake_at[id] = wake;
                        link_timer(id, LEVEL_ONE_SLOTS + LEVEL_TWO_SLOTS + wake[31:22]);
                        armed[id] = 1;
                        armed_total++;
                        push(0, 0, STAT_OK);
                    end else begin
                        push(0, 0, STAT_FAR);
                    end
                end
                OP_REMOVE: begin
                    if (!armed[id]) begin
                        push(0, 0, STAT_NOT_PND);
                    end else begin
                        unlink_timer(id);
                        armed[id] = 0;
                        if (armed_total > 0) armed_total--;
                        push(0, 0, STAT_OK);
                    end
                end
                OP_TICK: begin
                    if (now[11:0] == 0) begin
                        if (now[21:12] == 0 && now[31:22] < LEVEL_THREE_SLOTS) begin
                            src = LEVEL_ONE_SLOTS + LEVEL_TWO_SLOTS + now[31:22];
                            for (int g = 0; g < TIMER_COUNT && slot_used[src]; g++) begin
                                f = slot_head[src];
                                w = wake_at[f];
                                unlink_timer(f);
                                if (w[31:12] == now[31:12]) link_timer(f, w[11:0]);
                                else link_timer(f, LEVEL_ONE_SLOTS + w[21:12]);
                            end
                        end
                        src = LEVEL_ONE_SLOTS + now[21:12];
                        for (int g = 0; g < TIMER_COUNT && slot_used[src]; g++) begin
                            f = slot_head[src];
                            unlink_timer(f);
                            link_timer(f, wake_at[f][11:0]);
                        end
                    end
                    src = now[11:0];
                    for (int g = 0; g < TIMER_COUNT && slot_used[src]; g++) begin
                        f = slot_head[src];
                        unlink_timer(f);
                        armed[f] = 0;
                        if (armed_total > 0) armed_total--;
                        push(f, 1, STAT_OK);
                    end
                    if (due_results.size() == n) push(0, 0, STAT_OK);
                    now = now + 1;
                end
                default: push(0, 0, STAT_OK);
            endcase
            due_results[due_results.size()-1].last = 1'b1;
        endfunction

        task check(wheel_result_t got);
            wheel_result_t exp;
            if (due_results.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            exp = due_results.pop_front();
            if (got.id !== exp.id)
                report($sformatf("expired_id %0d, expected %0d", got.id, exp.id));
            if (got.fired !== exp.fired)
                report($sformatf("fired %0b, expected %0b", got.fired, exp.fired));
            if (got.last !== exp.last)
                report($sformatf("last %0b, expected %0b", got.last, exp.last));
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.count !== exp.count)
                report($sformatf("pending_count %0d, expected %0d", got.count, exp.count));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [1:0]  i_operation;
    logic [4:0]  i_timer_id;
    logic [31:0] i_wake_time;
    logic        busy;
    logic        o_strobe;
    logic [4:0]  o_expired_id;
    logic        o_fired;
    logic        o_last;
    logic [1:0]  o_status;
    logic [5:0]  o_pending_count;

    wheel_scoreboard sb;
    int              idle_pct;
    int              cycles = 0;

    hierarchical_timer_wheel dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_operation(i_operation),
        .i_timer_id(i_timer_id), .i_wake_time(i_wake_time), .busy(busy),
        .o_strobe(o_strobe), .o_expired_id(o_expired_id), .o_fired(o_fired),
        .o_last(o_last), .o_status(o_status), .o_pending_count(o_pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check('{id: o_expired_id, fired: o_fired, last: o_last, status: o_status,
                       count: o_pending_count});
    end

    task send(logic [1:0] op, logic [4:0] id, logic [31:0] wake);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_timer_id  <= id;
        i_wake_time <= wake;
        do @(posedge i_clk); while (busy);
        sb.note_input(op, id, wake);
    endtask

    task drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function logic [31:0] pick_wake();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return sb.now + $urandom_range(0, 40);
        if (r < 65) return sb.now - $urandom_range(1, 3000);
        if (r < 85) return sb.now + $urandom_range(0, 20000);
        return $urandom;
    endfunction

    initial begin
        int r;
        start       <= 1'b0;
        i_operation <= OP_ADD;
        i_timer_id  <= '0;
        i_wake_time <= '0;
        i_rst_n     <= 1'b0;
        idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_ADD, 0, 32'd0);
        send(OP_ADD, 0, 32'd7);
        send(OP_ADD, 1, 32'd5);
        send(OP_ADD, 2, 32'd5000);
        send(OP_ADD, 3, 32'h0100_0000);
        send(OP_ADD, 4, 32'hFFFF_FFFF);
        send(OP_ADD, 31, 32'h003F_FFFF);
        send(OP_REMOVE, 5, 32'd0);
        send(OP_REMOVE, 1, 32'd0);
        send(OP_UNUSED, 31, 32'hFFFF_FFFF);
        send(OP_TICK, 0, 32'd0);
        send(OP_TICK, 0, 32'd0);
        send(OP_ADD, 6, 32'd0);
        send(OP_ADD, 7, 32'd4096);
        send(OP_ADD, 8, 32'd4096);
        send(OP_ADD, 10, 32'd10);
        send(OP_ADD, 11, 32'd10);
        send(OP_ADD, 12, 32'd10);
        send(OP_REMOVE, 11, 32'd0);
        send(OP_ADD, 13, 32'd4200);
        send(OP_ADD, 14, 32'hAAAA_5555);
        repeat (12) send(OP_TICK, 0, 32'd0);
        drain();

        for (int n = 0; n < 300; n++) begin
            idle_pct = (n < 100) ? 20 : (n < 200) ? 68 : 0;
            if (n == 150) drain();
            r = $urandom_range(0, 99);
            if (r < 50) send(OP_ADD, 5'($urandom_range(0, 31)), pick_wake());
            else if (r < 70) send(OP_REMOVE, 5'($urandom_range(0, 31)), $urandom);
            else if (r < 97) send(OP_TICK, 5'($urandom_range(0, 31)), $urandom);
            else send(OP_UNUSED, 5'($urandom_range(0, 31)), $urandom);
        end
        drain();

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
